FILE: rtl/core/rkds_pkg.sv
package rkds_pkg;

    // Input field width and the fixed-point fraction of all distances.
    localparam int C_IN_BITS   = 32;
    localparam int C_FRAC_BITS = 16;

    // Numerator is (plane - offset) << 16: 33 + 16 bits signed.
    localparam int C_NUM_BITS     = C_IN_BITS + 1 + C_FRAC_BITS;
    localparam int C_NUM_MAG_BITS = C_NUM_BITS - 1;
    localparam int C_QUO_BITS     = C_NUM_BITS;
    localparam int C_DEN_BITS     = C_IN_BITS;
    localparam int C_CNT_BITS     = $clog2(C_NUM_MAG_BITS);

    // Slab counter and entry plane code.
    localparam int          C_PLANE_BITS = 3;
    localparam logic [2:0]  C_PLANE_NONE = 3'd7;

    typedef struct packed {
        logic                            start;
        logic signed [C_NUM_BITS-1:0]    num;
        logic signed [C_DEN_BITS-1:0]    den;
    } t_div_req;

    typedef struct packed {
        logic                            busy;
        logic                            done;
        logic signed [C_QUO_BITS-1:0]    quo;
    } t_div_rsp;

endpackage

FILE: rtl/core/rkds_div.sv
module rkds_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rkds_pkg::t_div_req  i_req,
    output rkds_pkg::t_div_rsp  o_rsp
);
    import rkds_pkg::*;

    logic                          r_busy;
    logic                          r_done;
    logic [C_CNT_BITS-1:0]         r_cnt;
    logic [C_DEN_BITS-1:0]         r_rem;
    logic [C_NUM_MAG_BITS-1:0]     r_num;
    logic [C_NUM_MAG_BITS-1:0]     r_quo;
    logic [C_DEN_BITS-1:0]         r_den;
    logic                          r_neg;
    logic signed [C_QUO_BITS-1:0]  r_res;

    logic signed [C_NUM_BITS-1:0]  w_num_abs;
    logic signed [C_DEN_BITS:0]    w_den_ext;
    logic signed [C_DEN_BITS:0]    w_den_abs;
    logic [C_DEN_BITS:0]           w_rem_sh;
    logic                          w_ge;
    logic [C_DEN_BITS:0]           w_rem_nx;
    logic [C_NUM_MAG_BITS-1:0]     w_quo_nx;
    logic [C_QUO_BITS-1:0]         w_quo_ext;

    always_comb begin
        w_num_abs = i_req.num[C_NUM_BITS-1] ? -i_req.num : i_req.num;
        w_den_ext = {i_req.den[C_DEN_BITS-1], i_req.den};
        w_den_abs = w_den_ext[C_DEN_BITS] ? -w_den_ext : w_den_ext;
        // One restoring step: shift in the next numerator bit, subtract if it fits.
        w_rem_sh  = {r_rem, r_num[C_NUM_MAG_BITS-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_den});
        w_rem_nx  = w_ge ? (w_rem_sh - {1'b0, r_den}) : w_rem_sh;
        w_quo_nx  = {r_quo[C_NUM_MAG_BITS-2:0], w_ge};
        w_quo_ext = {1'b0, w_quo_nx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_CNT_BITS'(C_NUM_MAG_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_num <= w_num_abs[C_NUM_MAG_BITS-1:0];
            r_quo <= '0;
            r_den <= w_den_abs[C_DEN_BITS-1:0];
            r_neg <= i_req.num[C_NUM_BITS-1] ^ i_req.den[C_DEN_BITS-1];
        end else if (r_busy) begin
            r_rem <= w_rem_nx[C_DEN_BITS-1:0];
            r_num <= {r_num[C_NUM_MAG_BITS-2:0], 1'b0};
            r_quo <= w_quo_nx;
            if (r_cnt == C_CNT_BITS'(C_NUM_MAG_BITS - 1)) begin
                r_res <= r_neg ? -$signed(w_quo_ext) : $signed(w_quo_ext);
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_res;

endmodule

FILE: rtl/core/ray_kdop_slab_intersect.sv
// A slab with a nonzero slope takes two 48-step quotients through the single bit-serial
// divider, first for the low plane and then for the high plane, and then one update;
// a zero-slope slab, or any slab after a miss, goes from acceptance straight to the update.
// One slab is in flight at a time; a result is emitted after slab NUM_SLABS-1.
// Reset (synchronous, active low) clears the interval to zero, the slab count to zero,
// the miss flag, and sets the entry plane to none; the output word is dropped.
module ray_kdop_slab_intersect #(
    parameter int NUM_SLABS  = 7,
    parameter int VALUE_BITS = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [rkds_pkg::C_IN_BITS-1:0] i_slab_low,
    input  logic signed [rkds_pkg::C_IN_BITS-1:0] i_slab_high,
    input  logic signed [rkds_pkg::C_IN_BITS-1:0] i_ray_offset,
    input  logic signed [rkds_pkg::C_IN_BITS-1:0] i_ray_slope,
    input  logic signed [rkds_pkg::C_IN_BITS-1:0] i_t_near_start,
    input  logic signed [rkds_pkg::C_IN_BITS-1:0] i_t_far_start,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_hit,
    output logic signed [rkds_pkg::C_IN_BITS-1:0] o_t_near,
    output logic signed [rkds_pkg::C_IN_BITS-1:0] o_t_far,
    output logic [rkds_pkg::C_PLANE_BITS-1:0]     o_entry_plane
);
    import rkds_pkg::*;

    localparam int QW = C_QUO_BITS;
    localparam logic signed [QW-1:0] C_VMAX =
        {{(QW - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
    localparam logic signed [QW-1:0] C_VMIN = ~C_VMAX;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DIV_LO = 2'd1;
    localparam logic [1:0] S_DIV_HI = 2'd2;
    localparam logic [1:0] S_UPD    = 2'd3;

    function automatic logic signed [VALUE_BITS-1:0] f_sat(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] c;
        c = (v > C_VMAX) ? C_VMAX : ((v < C_VMIN) ? C_VMIN : v);
        return c[VALUE_BITS-1:0];
    endfunction

    logic [1:0]                    r_state;
    logic [C_PLANE_BITS-1:0]       r_count;
    logic                          r_missed;
    logic [C_PLANE_BITS-1:0]       r_best;
    logic signed [VALUE_BITS-1:0]  r_near;
    logic signed [VALUE_BITS-1:0]  r_far;
    logic signed [VALUE_BITS-1:0]  r_q_lo;
    logic signed [VALUE_BITS-1:0]  r_q_hi;
    logic signed [C_IN_BITS-1:0]   r_lo;
    logic signed [C_IN_BITS-1:0]   r_hi;
    logic signed [C_IN_BITS-1:0]   r_off;
    logic signed [C_IN_BITS-1:0]   r_slope;
    logic                          r_out_valid;
    logic                          r_out_hit;
    logic signed [C_IN_BITS-1:0]   r_out_near;
    logic signed [C_IN_BITS-1:0]   r_out_far;
    logic [C_PLANE_BITS-1:0]       r_out_plane;

    t_div_req                      w_req;
    t_div_rsp                      w_rsp;
    logic                          w_accept;
    logic                          w_first;
    logic                          w_go_div;
    logic                          w_last;
    logic                          w_upd_go;
    logic signed [C_IN_BITS:0]     w_diff;
    logic signed [VALUE_BITS-1:0]  w_tn;
    logic signed [VALUE_BITS-1:0]  w_tf;
    logic                          w_raise;
    logic signed [VALUE_BITS-1:0]  n_near;
    logic signed [VALUE_BITS-1:0]  n_far;
    logic [C_PLANE_BITS-1:0]       n_best;
    logic                          n_missed;
    logic signed [QW-1:0]          w_near_ext;
    logic signed [QW-1:0]          w_far_ext;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_first  = (r_count == '0);
    assign w_go_div = (w_first || !r_missed) && (i_ray_slope != '0);
    assign w_last   = (r_count == C_PLANE_BITS'(NUM_SLABS - 1));
    assign w_upd_go = (r_state == S_UPD) && !(w_last && r_out_valid && !i_ready);

    always_comb begin
        w_req.start = 1'b0;
        w_diff      = $signed({i_slab_low[C_IN_BITS-1], i_slab_low})
                    - $signed({i_ray_offset[C_IN_BITS-1], i_ray_offset});
        w_req.den   = i_ray_slope;
        if (w_accept && w_go_div) begin
            w_req.start = 1'b1;
        end else if (r_state == S_DIV_LO && w_rsp.done) begin
            w_req.start = 1'b1;
            w_diff      = $signed({r_hi[C_IN_BITS-1], r_hi})
                        - $signed({r_off[C_IN_BITS-1], r_off});
            w_req.den   = r_slope;
        end
        w_req.num = {w_diff, {C_FRAC_BITS{1'b0}}};
    end

    rkds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Interval narrowing for the slab held in the input registers.
    always_comb begin
        w_tn     = r_slope[C_IN_BITS-1] ? r_q_hi : r_q_lo;
        w_tf     = r_slope[C_IN_BITS-1] ? r_q_lo : r_q_hi;
        w_raise  = 1'b0;
        n_near   = r_near;
        n_far    = r_far;
        n_best   = r_best;
        n_missed = r_missed;
        if (!r_missed) begin
            if (r_slope == '0) begin
                n_missed = (r_off < r_lo) || (r_off > r_hi);
            end else begin
                w_raise  = (w_tn > r_near);
                n_near   = w_raise ? w_tn : r_near;
                n_best   = w_raise ? r_count : r_best;
                n_far    = (w_tf < r_far) ? w_tf : r_far;
                n_missed = (n_near > n_far);
            end
        end
        w_near_ext = QW'(n_near);
        w_far_ext  = QW'(n_far);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_missed    <= 1'b0;
            r_best      <= C_PLANE_NONE;
            r_near      <= '0;
            r_far       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_upd_go && w_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_first) begin
                            r_near   <= f_sat(QW'(i_t_near_start));
                            r_far    <= f_sat(QW'(i_t_far_start));
                            r_best   <= C_PLANE_NONE;
                            r_missed <= 1'b0;
                        end
                        r_state <= w_go_div ? S_DIV_LO : S_UPD;
                    end
                end
                S_DIV_LO: begin
                    if (w_rsp.done) begin
                        r_state <= S_DIV_HI;
                    end
                end
                S_DIV_HI: begin
                    if (w_rsp.done) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (w_upd_go) begin
                        r_near   <= n_near;
                        r_far    <= n_far;
                        r_best   <= n_best;
                        r_missed <= n_missed;
                        r_state  <= S_IDLE;
                        if (w_last) begin
                            r_count <= '0;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lo    <= i_slab_low;
            r_hi    <= i_slab_high;
            r_off   <= i_ray_offset;
            r_slope <= i_ray_slope;
        end
        if (r_state == S_DIV_LO && w_rsp.done) begin
            r_q_lo <= f_sat(w_rsp.quo);
        end
        if (r_state == S_DIV_HI && w_rsp.done) begin
            r_q_hi <= f_sat(w_rsp.quo);
        end
        if (w_upd_go && w_last) begin
            r_out_hit   <= !n_missed;
            r_out_near  <= w_near_ext[C_IN_BITS-1:0];
            r_out_far   <= w_far_ext[C_IN_BITS-1:0];
            r_out_plane <= n_best;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_t_near      = r_out_near;
    assign o_t_far       = r_out_far;
    assign o_entry_plane = r_out_plane;

    // The divider runs only while the sequencer waits on it.
    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_rsp.busy)
        else $error("divider busy while the block is idle");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_DIV_LO || r_state == S_DIV_HI))
        else $error("quotient finished outside a divide state");

    a_plane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best == C_PLANE_NONE) || (r_best < C_PLANE_BITS'(NUM_SLABS)))
        else $error("entry plane beyond the slab count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < C_PLANE_BITS'(NUM_SLABS))
        else $error("slab counter out of range");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import rkds_pkg::*;

    localparam int NUM_SLABS  = 7;
    localparam int VALUE_BITS = 32;
    localparam int Q_MAX      = 32'h7fff_ffff;
    localparam int Q_MIN      = -Q_MAX - 1;
    localparam int Q_ONE      = 1 << C_FRAC_BITS;
    localparam int RANDOM_TESTS = 220;
    localparam int QUIET_TESTS  = 20;
    localparam int LONG_HOLD_CYCLES = 2500;

    typedef struct {
        logic signed [C_IN_BITS-1:0] low;
        logic signed [C_IN_BITS-1:0] high;
        logic signed [C_IN_BITS-1:0] offset;
        logic signed [C_IN_BITS-1:0] slope;
        logic signed [C_IN_BITS-1:0] near_start;
        logic signed [C_IN_BITS-1:0] far_start;
    } t_slab;

    typedef struct {
        logic                        hit;
        logic [C_IN_BITS-1:0]        t_near;
        logic [C_IN_BITS-1:0]        t_far;
        logic [C_PLANE_BITS-1:0]     plane;
    } t_interval;

    // Tracks the running ray interval and holds the intervals still owed by the block.
    class t_interval_tracker;
        longint              near_t;
        longint              far_t;
        logic [2:0]          entry;
        int unsigned         slab_idx;
        bit                  missed;
        t_interval           pending_intervals[$];
        int unsigned         errors;

        function new();
            near_t   = 0;
            far_t    = 0;
            entry    = C_PLANE_NONE;
            slab_idx = 0;
            missed   = 1'b0;
            errors   = 0;
        endfunction

        function longint clamp_value(longint v);
            longint hi_lim;
            longint lo_lim;
            hi_lim = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
            lo_lim = -hi_lim - 1;
            if (v > hi_lim) return hi_lim;
            if (v < lo_lim) return lo_lim;
            return v;
        endfunction

        function longint crossing_at(logic signed [C_IN_BITS-1:0] plane,
                                     logic signed [C_IN_BITS-1:0] offset,
                                     logic signed [C_IN_BITS-1:0] slope);
            longint num;
            num = (longint'(plane) - longint'(offset)) * 64'sd65536;
            // SystemVerilog division truncates toward zero.
            return clamp_value(num / longint'(slope));
        endfunction

        function void note_slab(t_slab s);
            longint    tn;
            longint    tf;
            longint    tmp;
            t_interval r;
            if (slab_idx == 0) begin
                near_t = clamp_value(longint'(s.near_start));
                far_t  = clamp_value(longint'(s.far_start));
                entry  = C_PLANE_NONE;
                missed = 1'b0;
            end
            if (!missed) begin
                if (s.slope == 0) begin
                    if (s.offset < s.low || s.offset > s.high) missed = 1'b1;
                end else begin
                    tn = crossing_at(s.low, s.offset, s.slope);
                    tf = crossing_at(s.high, s.offset, s.slope);
                    if (s.slope < 0) begin
                        tmp = tn;
                        tn  = tf;
                        tf  = tmp;
                    end
                    if (tn > near_t) begin
                        near_t = tn;
                        entry  = slab_idx[2:0];
                    end
                    if (tf < far_t) far_t = tf;
                    if (near_t > far_t) missed = 1'b1;
                end
            end
            if (slab_idx + 1 >= NUM_SLABS) begin
                slab_idx   = 0;
                r.hit      = !missed;
                r.t_near   = near_t[31:0];
                r.t_far    = far_t[31:0];
                r.plane    = entry;
                pending_intervals.insert(pending_intervals.size(), r);
            end else begin
                slab_idx++;
            end
        endfunction

        function void check_interval(t_interval got);
            t_interval exp;
            if (pending_intervals.size() == 0) begin
                $display("%0t ERROR unexpected result word: hit %b near %h far %h plane %0d",
                         $time, got.hit, got.t_near, got.t_far, got.plane);
                errors++;
                return;
            end
            exp = pending_intervals.pop_front();
            if (got.hit !== exp.hit) begin
                $display("%0t ERROR hit: expected %b, actual %b", $time, exp.hit, got.hit);
                errors++;
            end
            if (got.t_near !== exp.t_near) begin
                $display("%0t ERROR t_near: expected %h, actual %h",
                         $time, exp.t_near, got.t_near);
                errors++;
            end
            if (got.t_far !== exp.t_far) begin
                $display("%0t ERROR t_far: expected %h, actual %h",
                         $time, exp.t_far, got.t_far);
                errors++;
            end
            if (got.plane !== exp.plane) begin
                $display("%0t ERROR entry_plane: expected %0d, actual %0d",
                         $time, exp.plane, got.plane);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic signed [C_IN_BITS-1:0]   i_slab_low;
    logic signed [C_IN_BITS-1:0]   i_slab_high;
    logic signed [C_IN_BITS-1:0]   i_ray_offset;
    logic signed [C_IN_BITS-1:0]   i_ray_slope;
    logic signed [C_IN_BITS-1:0]   i_t_near_start;
    logic signed [C_IN_BITS-1:0]   i_t_far_start;
    logic                          o_valid;
    logic                          i_ready;
    logic                          o_hit;
    logic signed [C_IN_BITS-1:0]   o_t_near;
    logic signed [C_IN_BITS-1:0]   o_t_far;
    logic [C_PLANE_BITS-1:0]       o_entry_plane;

    t_interval_tracker tracker = new();
    bit quiet_tail;

    ray_kdop_slab_intersect #(
        .NUM_SLABS  (NUM_SLABS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_slab_low     (i_slab_low),
        .i_slab_high    (i_slab_high),
        .i_ray_offset   (i_ray_offset),
        .i_ray_slope    (i_ray_slope),
        .i_t_near_start (i_t_near_start),
        .i_t_far_start  (i_t_far_start),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_t_near       (o_t_near),
        .o_t_far        (o_t_far),
        .o_entry_plane  (o_entry_plane)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int signed_rand(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_slab make_slab(int lo, int hi, int off, int slope, int ns, int fs);
        t_slab s;
        s.low        = lo;
        s.high       = hi;
        s.offset     = off;
        s.slope      = slope;
        s.near_start = ns;
        s.far_start  = fs;
        return s;
    endfunction

    function automatic t_slab noise_slab();
        t_slab s;
        s.low        = $urandom;
        s.high       = $urandom;
        s.offset     = $urandom;
        s.slope      = ($urandom_range(0, 7) == 0) ? 32'sd0 : $urandom;
        s.near_start = $urandom;
        s.far_start  = $urandom;
        return s;
    endfunction

    // Builds a slab around the point the ray reaches at t_aim; when through is
    // clear the slab is placed beside that point instead.
    function automatic t_slab aimed_slab(longint t_aim, bit through);
        t_slab  s;
        longint slope;
        longint proj;
        longint m_lo;
        longint m_hi;
        longint lo;
        longint hi;
        s = noise_slab();
        s.offset = signed_rand(1 << 24);
        if ($urandom_range(0, 9) == 0) slope = 0;
        else if ($urandom_range(0, 15) == 0) slope = signed_rand(1 << 30);
        else slope = signed_rand(1 << 18);
        proj = longint'(s.offset) + ((slope * t_aim) >>> C_FRAC_BITS);
        if (proj > (64'sd1 <<< 30)) proj = 64'sd1 <<< 30;
        if (proj < -(64'sd1 <<< 30)) proj = -(64'sd1 <<< 30);
        if (slope == 0) proj = longint'(s.offset);
        m_lo = $urandom_range(0, 1 << 22);
        m_hi = $urandom_range(0, 1 << 22);
        if (through) begin
            lo = proj - m_lo;
            hi = proj + m_hi;
        end else if ($urandom_range(0, 1) == 0) begin
            lo = proj + 1 + m_lo;
            hi = lo + m_hi;
        end else begin
            hi = proj - 1 - m_lo;
            lo = hi - m_hi;
        end
        s.low   = lo[31:0];
        s.high  = hi[31:0];
        s.slope = slope[31:0];
        return s;
    endfunction

    task automatic send_slab(t_slab s);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_slab_low     <= s.low;
        i_slab_high    <= s.high;
        i_ray_offset   <= s.offset;
        i_ray_slope    <= s.slope;
        i_t_near_start <= s.near_start;
        i_t_far_start  <= s.far_start;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.note_slab(s);
    endtask

    task automatic send_random_test(int kind);
        t_slab  s;
        longint t_aim;
        t_aim = $urandom_range(0, 1 << 22);
        for (int k = 0; k < NUM_SLABS; k++) begin
            if (kind == 0) s = aimed_slab(t_aim, $urandom_range(0, 11) != 0);
            else if (kind == 1) s = noise_slab();
            else begin
                s = ($urandom_range(0, 1) == 0) ? aimed_slab(t_aim, $urandom_range(0, 1))
                                                : noise_slab();
                if ($urandom_range(0, 2) == 0) begin
                    s.low  = s.high;
                    s.high = s.offset - 1;
                end
            end
            if (k == 0 && kind == 0) begin
                s.near_start = ($urandom_range(0, 3) == 0) ? -int'($urandom_range(0, 1 << 24))
                                                           : 0;
                s.far_start  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1 << 22, Q_MAX))
                                                           : Q_MAX;
            end
            send_slab(s);
        end
    endtask

    // Result side: random stalls, one long hold-off, and a clean tail.
    initial begin
        int        idle_left;
        int        hold_left;
        int        results_seen;
        bit        hold_done;
        t_interval got;
        idle_left    = 0;
        hold_left    = 0;
        results_seen = 0;
        hold_done    = 1'b0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_ready && o_valid) begin
                got.hit    = o_hit;
                got.t_near = o_t_near;
                got.t_far  = o_t_far;
                got.plane  = o_entry_plane;
                tracker.check_interval(got);
                results_seen++;
            end
            if (!hold_done && results_seen >= 30) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (quiet_tail) begin
                i_ready <= 1'b1;
            end else if (idle_left > 0) begin
                idle_left--;
                i_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                idle_left = $urandom_range(1, 6) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        quiet_tail     = 1'b0;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_slab_low     <= '0;
        i_slab_high    <= '0;
        i_ray_offset   <= '0;
        i_ray_slope    <= '0;
        i_t_near_start <= '0;
        i_t_far_start  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes: zero slope inside, saturated quotients, most negative slope,
        // equal crossing, near equal to far, and a miss on the last slab.
        send_slab(make_slab(Q_MIN, Q_MAX, 0, 0, Q_MIN, Q_MAX));
        send_slab(make_slab(-Q_ONE, Q_ONE, 0, 1, $urandom, $urandom));
        send_slab(make_slab(Q_MIN, Q_MAX, Q_MAX, Q_MIN, $urandom, $urandom));
        send_slab(make_slab(0, 10 * Q_ONE, 0, Q_ONE, $urandom, $urandom));
        send_slab(make_slab(-5 * Q_ONE, 20 * Q_ONE, 0, -Q_ONE, $urandom, $urandom));
        send_slab(make_slab(0, 0, 0, Q_ONE, $urandom, $urandom));
        send_slab(make_slab(Q_MAX, Q_MAX, Q_MIN, Q_MAX, $urandom, $urandom));
        // Zero slope with the origin below the slab misses; later slabs change nothing.
        send_slab(make_slab(10 * Q_ONE, 20 * Q_ONE, 5 * Q_ONE, 0, 0, Q_MAX));
        send_slab(make_slab(2 * Q_ONE, 50 * Q_ONE, 0, Q_ONE, $urandom, $urandom));
        send_slab(make_slab(-10 * Q_ONE, 40 * Q_ONE, 0, Q_ONE / 2, $urandom, $urandom));
        send_slab(make_slab(6 * Q_ONE, 60 * Q_ONE, 0, 2 * Q_ONE, $urandom, $urandom));
        send_slab(make_slab(-8 * Q_ONE, 4 * Q_ONE, 0, -Q_ONE, $urandom, $urandom));
        send_slab(make_slab(5 * Q_ONE, 9 * Q_ONE, Q_ONE, Q_ONE, $urandom, $urandom));
        send_slab(make_slab(Q_MIN, Q_MAX, Q_MAX, 1, $urandom, $urandom));
        // A hit whose entry plane is set by a later slab, ending on a zero slope
        // with the origin exactly on both planes.
        send_slab(make_slab(2 * Q_ONE, 50 * Q_ONE, 0, Q_ONE, -Q_ONE, 100 * Q_ONE));
        send_slab(make_slab(-10 * Q_ONE, 40 * Q_ONE, 0, Q_ONE / 2, $urandom, $urandom));
        send_slab(make_slab(6 * Q_ONE, 60 * Q_ONE, 0, 2 * Q_ONE, $urandom, $urandom));
        send_slab(make_slab(-8 * Q_ONE, 4 * Q_ONE, 0, -Q_ONE, $urandom, $urandom));
        send_slab(make_slab(5 * Q_ONE, 9 * Q_ONE, Q_ONE, Q_ONE, $urandom, $urandom));
        send_slab(make_slab(4 * Q_ONE, 20 * Q_ONE, 0, Q_ONE, $urandom, $urandom));
        send_slab(make_slab(7 * Q_ONE, 7 * Q_ONE, 7 * Q_ONE, 0, $urandom, $urandom));

        for (int t = 0; t < RANDOM_TESTS; t++) begin
            int pick;
            pick = $urandom_range(0, 9);
            if (t >= RANDOM_TESTS - QUIET_TESTS) quiet_tail = 1'b1;
            send_random_test((pick < 7) ? 0 : (pick < 9) ? 1 : 2);
        end
        i_valid <= 1'b0;

        for (int w = 0; w < 50000 && tracker.pending_intervals.size() != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (250) @(posedge i_clk);
        if (tracker.pending_intervals.size() != 0) begin
            $display("%0t ERROR %0d result words never arrived",
                     $time, tracker.pending_intervals.size());
            tracker.errors++;
        end
        if (tracker.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
